// ----- hw/rtl/leased_output_command_guard_core_assert.svh -----
// Assertion macros for the leased output command guard.
`ifndef LEASED_OUTPUT_COMMAND_GUARD_CORE_ASSERT_SVH
`define LEASED_OUTPUT_COMMAND_GUARD_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LOCG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LOCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/locg_pkg.sv -----
// Shared types and constants of the leased output command guard.
package locg_pkg;

    localparam int unsigned OUT_BITS  = 8;
    localparam int unsigned SEQ_BITS  = 16;
    localparam int unsigned TIME_BITS = 32;
    localparam int unsigned SESS_BITS = 16;
    localparam int unsigned TICK_BITS = 8;

    localparam logic [TIME_BITS-1:0] TICK_MS = 32'd10;

    localparam int unsigned IN_FIELDS_W  = 2 * TIME_BITS + SESS_BITS + SEQ_BITS + TICK_BITS
                                         + 2 * OUT_BITS + 1;
    localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = OUT_BITS + SEQ_BITS + 4;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_COMMAND,
        OP_TIME_CHECK,
        OP_BUS_STATE,
        OP_FAULT
    } t_op;

    typedef enum logic [2:0] {
        RC_APPLIED,
        RC_SESSION,
        RC_NOT_READY,
        RC_STALE,
        RC_EXPIRED,
        RC_NONE
    } t_result_code;

    typedef enum logic [1:0] {
        FK_NONE,
        FK_COMM_LOSS,
        FK_INTERNAL
    } t_fault_kind;

    typedef enum logic {
        CFG_SESS_NUM,
        CFG_NODE_OK
    } t_cfg_index;

    typedef struct packed {
        t_op                   op;
        logic [TIME_BITS-1:0]  now_time;
        logic [TIME_BITS-1:0]  receive_time;
        logic [SESS_BITS-1:0]  cmd_session;
        logic [SEQ_BITS-1:0]   cmd_sequence;
        logic [TICK_BITS-1:0]  validity_ticks;
        logic [OUT_BITS-1:0]   write_mask;
        logic [OUT_BITS-1:0]   write_values;
        logic                  bus_ready_value;
    } t_cmd;

    typedef struct packed {
        t_result_code          result_code;
        logic [OUT_BITS-1:0]   out_view;
        logic [SEQ_BITS-1:0]   echo_sequence;
        logic                  lease_expired;
        logic                  interlock_ok;
        t_fault_kind           fault_kind;
    } t_result;

    typedef struct packed {
        logic [SESS_BITS-1:0]  sess_num;
        logic                  node_ok;
    } t_cfg;

    typedef struct packed {
        logic                  lease_on;
        logic                  bus_up;
        logic                  fault_latch;
    } t_guard_status;

endpackage

// ----- hw/rtl/locg_in_reg.sv -----
// Input register stage holding one accepted command transfer.
module locg_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  locg_pkg::t_cmd   i_cmd,
    input  logic             i_advance,
    output logic             o_valid,
    output locg_pkg::t_cmd   o_cmd
);

    logic           r_valid;
    logic           n_valid;
    locg_pkg::t_cmd r_cmd;
    logic           w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ----- hw/rtl/locg_guard.sv -----
// Lease, interlock and command checks with the guard state registers.
module locg_guard (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  locg_pkg::t_cmd           i_cmd,
    input  locg_pkg::t_cfg           i_cfg,
    output locg_pkg::t_result        o_result,
    output locg_pkg::t_guard_status  o_status
);

    logic [locg_pkg::OUT_BITS-1:0]  r_out_bits;
    logic [locg_pkg::OUT_BITS-1:0]  n_out_bits;
    logic                           r_lease_on;
    logic                           n_lease_on;
    logic [locg_pkg::TIME_BITS-1:0] r_lease_deadline;
    logic [locg_pkg::TIME_BITS-1:0] n_lease_deadline;
    logic [locg_pkg::SEQ_BITS-1:0]  r_last_seq;
    logic [locg_pkg::SEQ_BITS-1:0]  n_last_seq;
    logic                           r_have_seq;
    logic                           n_have_seq;
    logic                           r_bus_up;
    logic                           n_bus_up;
    logic                           r_fault;
    logic                           n_fault;

    logic [locg_pkg::TIME_BITS-1:0] w_lease_gap;
    logic                           w_expire;
    logic [locg_pkg::SEQ_BITS-1:0]  w_seq_dist;
    logic                           w_newer;
    logic [locg_pkg::TIME_BITS-1:0] w_new_deadline;
    logic [locg_pkg::TIME_BITS-1:0] w_new_gap;
    logic                           w_cmd_expired;
    logic                           w_interlock_pre;
    locg_pkg::t_result_code         w_code;

    assign w_lease_gap     = i_cmd.now_time - r_lease_deadline;
    assign w_expire        = r_lease_on && !w_lease_gap[locg_pkg::TIME_BITS-1];
    assign w_seq_dist      = i_cmd.cmd_sequence - r_last_seq;
    assign w_newer         = (|w_seq_dist) && !w_seq_dist[locg_pkg::SEQ_BITS-1];
    assign w_new_deadline  = i_cmd.receive_time
                           + locg_pkg::TIME_BITS'(i_cmd.validity_ticks) * locg_pkg::TICK_MS;
    assign w_new_gap       = i_cmd.now_time - w_new_deadline;
    assign w_cmd_expired   = !w_new_gap[locg_pkg::TIME_BITS-1];
    assign w_interlock_pre = i_cfg.node_ok && r_bus_up && !r_fault;

    always_comb begin
        n_out_bits       = r_out_bits;
        n_lease_on       = r_lease_on;
        n_lease_deadline = r_lease_deadline;
        n_last_seq       = r_last_seq;
        n_have_seq       = r_have_seq;
        n_bus_up         = r_bus_up;
        n_fault          = r_fault;
        w_code           = locg_pkg::RC_NONE;

        if (w_expire) begin
            n_out_bits       = '0;
            n_lease_on       = 1'b0;
            n_lease_deadline = '0;
        end

        unique case (i_cmd.op)
            locg_pkg::OP_COMMAND: begin
                if (i_cmd.cmd_session != i_cfg.sess_num) begin
                    w_code = locg_pkg::RC_SESSION;
                end else if (!w_interlock_pre) begin
                    w_code = locg_pkg::RC_NOT_READY;
                end else if (r_have_seq && !w_newer) begin
                    w_code = locg_pkg::RC_STALE;
                end else if (w_cmd_expired) begin
                    w_code = locg_pkg::RC_EXPIRED;
                end else begin
                    w_code           = locg_pkg::RC_APPLIED;
                    n_out_bits       = (n_out_bits & ~i_cmd.write_mask)
                                     | (i_cmd.write_values & i_cmd.write_mask);
                    n_last_seq       = i_cmd.cmd_sequence;
                    n_have_seq       = 1'b1;
                    n_lease_on       = 1'b1;
                    n_lease_deadline = w_new_deadline;
                end
            end
            locg_pkg::OP_TIME_CHECK: begin
            end
            locg_pkg::OP_BUS_STATE: begin
                n_bus_up = i_cmd.bus_ready_value;
                if (!i_cmd.bus_ready_value) begin
                    n_out_bits       = '0;
                    n_lease_on       = 1'b0;
                    n_lease_deadline = '0;
                end
            end
            locg_pkg::OP_FAULT: begin
                n_fault          = 1'b1;
                n_out_bits       = '0;
                n_lease_on       = 1'b0;
                n_lease_deadline = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.result_code   = w_code;
        o_result.out_view      = n_out_bits;
        o_result.echo_sequence = (i_cmd.op == locg_pkg::OP_COMMAND) ? i_cmd.cmd_sequence : '0;
        o_result.lease_expired = w_expire;
        o_result.interlock_ok  = i_cfg.node_ok && n_bus_up && !n_fault;
        if (n_fault || !i_cfg.node_ok) begin
            o_result.fault_kind = locg_pkg::FK_INTERNAL;
        end else if (!n_bus_up) begin
            o_result.fault_kind = locg_pkg::FK_COMM_LOSS;
        end else begin
            o_result.fault_kind = locg_pkg::FK_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_bits       <= '0;
            r_lease_on       <= 1'b0;
            r_lease_deadline <= '0;
            r_last_seq       <= '0;
            r_have_seq       <= 1'b0;
            r_bus_up         <= 1'b1;
            r_fault          <= 1'b0;
        end else if (i_advance) begin
            r_out_bits       <= n_out_bits;
            r_lease_on       <= n_lease_on;
            r_lease_deadline <= n_lease_deadline;
            r_last_seq       <= n_last_seq;
            r_have_seq       <= n_have_seq;
            r_bus_up         <= n_bus_up;
            r_fault          <= n_fault;
        end
    end

    assign o_status.lease_on    = r_lease_on;
    assign o_status.bus_up      = r_bus_up;
    assign o_status.fault_latch = r_fault;

endmodule

// ----- hw/rtl/locg_out_reg.sv -----
// Result register stage holding one result until its transfer completes.
module locg_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  locg_pkg::t_result   i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output locg_pkg::t_result   o_result
);

    logic              r_valid;
    logic              n_valid;
    locg_pkg::t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/leased_output_command_guard_core.sv -----
// Top level of the leased output command guard.
//
// Input stream: one transfer per item; tuser carries the op, tdata the command
// fields. Output stream: one result transfer per input item, in order; tuser
// carries the result code, tdata the output bits, echoed sequence and status.
// Configuration: index 0 sets the session number (zero stored as one), index 1
// the identity-ready flag; write only while no item is in flight.
// A result is registered as its item leaves the input register. Throughput:
// one item per cycle unless stalled; the input register, the combinational
// checks with the guard state and the result register form a two-stage path.
// Reset: outputs zero, no lease, no sequence seen, bus up, no fault, session
// number one, identity not ready; both stream registers empty.
// Stall: a held result keeps its register; one more item waits in the input
// register, then s_axis_tready drops until the result transfer completes.
`include "leased_output_command_guard_core_assert.svh"

module leased_output_command_guard_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_time, receive_time, cmd_session, cmd_sequence, validity_ticks,
    // write_mask, write_values, bus_ready_value, zero fill
    input  logic [locg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // op
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // output bits, echo_sequence, lease_expired, interlock_ok, fault_kind,
    // zero fill
    output logic [locg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // result_code
    output logic [2:0]                            m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic                                  i_cfg_index,
    input  logic [locg_pkg::SESS_BITS-1:0]        i_cfg_data
);

    logic                    r_node_ok;
    logic [locg_pkg::SESS_BITS-1:0] r_sess_num;
    locg_pkg::t_cfg          w_cfg;
    locg_pkg::t_cmd          w_in_cmd;
    locg_pkg::t_cmd          w_cmd;
    logic                    w_in_valid;
    logic                    w_advance;
    locg_pkg::t_result       w_result;
    locg_pkg::t_result       w_out_result;
    locg_pkg::t_guard_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess_num <= locg_pkg::SESS_BITS'(1);
            r_node_ok  <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == locg_pkg::CFG_SESS_NUM) begin
                r_sess_num <= (i_cfg_data == '0) ? locg_pkg::SESS_BITS'(1) : i_cfg_data;
            end else begin
                r_node_ok <= i_cfg_data[0];
            end
        end
    end

    assign w_cfg.sess_num = r_sess_num;
    assign w_cfg.node_ok  = r_node_ok;

    assign w_in_cmd.op              = locg_pkg::t_op'(s_axis_tuser);
    assign w_in_cmd.now_time        = s_axis_tdata[31:0];
    assign w_in_cmd.receive_time    = s_axis_tdata[63:32];
    assign w_in_cmd.cmd_session     = s_axis_tdata[79:64];
    assign w_in_cmd.cmd_sequence    = s_axis_tdata[95:80];
    assign w_in_cmd.validity_ticks  = s_axis_tdata[103:96];
    assign w_in_cmd.write_mask      = s_axis_tdata[111:104];
    assign w_in_cmd.write_values    = s_axis_tdata[119:112];
    assign w_in_cmd.bus_ready_value = s_axis_tdata[120];

    assign w_advance = w_in_valid && (!m_axis_tvalid || m_axis_tready);

    locg_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (w_in_cmd),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_cmd     (w_cmd)
    );

    locg_guard u_guard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_cmd     (w_cmd),
        .i_cfg     (w_cfg),
        .o_result  (w_result),
        .o_status  (w_status)
    );

    locg_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_result)
    );

    assign m_axis_tuser = w_out_result.result_code;
    assign m_axis_tdata = {
        (locg_pkg::OUT_TDATA_W - locg_pkg::OUT_FIELDS_W)'(0),
        w_out_result.fault_kind,
        w_out_result.interlock_ok,
        w_out_result.lease_expired,
        w_out_result.echo_sequence,
        w_out_result.out_view
    };

    `LOCG_ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready,
        w_in_valid && m_axis_tvalid && !m_axis_tready, "input stalled without full pipeline")
    `LOCG_ASSERT_NEXT(a_fault_holds, i_clk, i_rst_n, w_status.fault_latch,
        w_status.fault_latch, "fault latch cleared without reset")
    `LOCG_ASSERT_NEXT(a_applied_starts_lease, i_clk, i_rst_n,
        w_advance && (w_result.result_code == locg_pkg::RC_APPLIED),
        w_status.lease_on && m_axis_tvalid, "applied command left no lease")
    `LOCG_ASSERT_IMPLIES(a_interlock_matches_fault, i_clk, i_rst_n, m_axis_tvalid,
        w_out_result.interlock_ok == (w_out_result.fault_kind == locg_pkg::FK_NONE),
        "interlock status disagrees with fault kind")

endmodule
